// ===== hw/rtl/bvse_pkg.sv =====
// Shared types, operation codes and helper functions of the bit vector store engine.
`default_nettype none

package bvse_pkg;

    localparam int STORE_WORDS = 32;
    localparam int WORD_WIDTH  = 32;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int BIT_AW      = $clog2(WORD_WIDTH);
    localparam int INDEX_W     = WORD_AW + BIT_AW;
    localparam int NWORDS_W    = WORD_AW + 1;
    localparam int CFG_W       = 11;
    localparam int COUNT_W     = 11;
    localparam int POP_W       = BIT_AW + 1;

    localparam logic [CFG_W-1:0] BITS_IN_USE_RESET = 11'd1024;

    // Operation codes carried in the func field of a request.
    localparam logic [3:0] FN_SET     = 4'd0;
    localparam logic [3:0] FN_CLR     = 4'd1;
    localparam logic [3:0] FN_GET     = 4'd2;
    localparam logic [3:0] FN_CLR_ALL = 4'd3;
    localparam logic [3:0] FN_RANGE   = 4'd4;
    localparam logic [3:0] FN_COUNT   = 4'd5;
    localparam logic [3:0] FN_FIND    = 4'd6;
    localparam logic [3:0] FN_WR_WORD = 4'd7;
    localparam logic [3:0] FN_RD_WORD = 4'd8;

    localparam logic [31:0] POP_M1 = 32'h5555_5555;
    localparam logic [31:0] POP_M2 = 32'h3333_3333;
    localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;

    typedef struct packed {
        logic [3:0]            func;
        logic [INDEX_W-1:0]    bit_pos;
        logic [INDEX_W-1:0]    end_index;
        logic [WORD_AW-1:0]    word_addr;
        logic [WORD_WIDTH-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic                  bit_value;
        logic [COUNT_W-1:0]    set_count;
        logic [INDEX_W-1:0]    active_index;
        logic                  found;
        logic [WORD_WIDTH-1:0] word_out;
        logic                  status;
    } rsp_t;

    // Control handed from the sequencer to the word unit.
    typedef struct packed {
        logic [3:0]        op;
        logic [BIT_AW-1:0] lo;
        logic [BIT_AW-1:0] hi;
    } wu_ctl_t;

    // What the word unit reports for the word it was given.
    typedef struct packed {
        logic                  wr_en;
        logic [WORD_WIDTH-1:0] wr_data;
        logic [POP_W-1:0]      pop;
        logic                  hit;
        logic [BIT_AW-1:0]     pos;
        logic                  bit_val;
    } wu_res_t;

    function automatic logic [POP_W-1:0] pop32(input logic [WORD_WIDTH-1:0] v);
        logic [WORD_WIDTH-1:0] a;
        logic [WORD_WIDTH-1:0] b;
        logic [WORD_WIDTH-1:0] c;
        a = v - ((v >> 1) & POP_M1);
        b = (a & POP_M2) + ((a >> 2) & POP_M2);
        c = (b + (b >> 4)) & POP_M4;
        return POP_W'(c[7:0]) + POP_W'(c[15:8]) + POP_W'(c[23:16]) + POP_W'(c[31:24]);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bvse_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bvse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bvse_word_unit.sv =====
// Shared word unit: masks, modifies, counts and searches one stored word.
`default_nettype none

module bvse_word_unit (
    input  wire bvse_pkg::wu_ctl_t                   ctl,
    input  wire logic [bvse_pkg::WORD_WIDTH-1:0]     data,
    output      bvse_pkg::wu_res_t                   res
);

    localparam logic [bvse_pkg::BIT_AW-1:0] BIT_MAX = bvse_pkg::BIT_AW'(bvse_pkg::WORD_WIDTH - 1);

    logic [bvse_pkg::WORD_WIDTH-1:0] mask;
    logic [bvse_pkg::WORD_WIDTH-1:0] masked;
    logic [bvse_pkg::WORD_WIDTH-1:0] lowest;
    logic [bvse_pkg::BIT_AW-1:0]     pos;

    // The mask covers bit positions lo through hi inclusive.
    assign mask   = ({bvse_pkg::WORD_WIDTH{1'b1}} << ctl.lo)
                  & ({bvse_pkg::WORD_WIDTH{1'b1}} >> (BIT_MAX - ctl.hi));
    assign masked = data & mask;
    assign lowest = masked & (~masked + 1'b1);

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < bvse_pkg::WORD_WIDTH; i++)
        begin
            if (lowest[i])
            begin
                pos = pos | bvse_pkg::BIT_AW'(i);
            end
        end
    end

    always_comb
    begin
        res         = '0;
        res.pop     = bvse_pkg::pop32(masked);
        res.hit     = |masked;
        res.pos     = pos;
        res.bit_val = |masked;
        case (ctl.op)
            bvse_pkg::FN_SET,
            bvse_pkg::FN_RANGE:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = data | mask;
            end
            bvse_pkg::FN_CLR:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = data & ~mask;
            end
            default:
            begin
                res.wr_en   = 1'b0;
                res.wr_data = data;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bit_vector_store_engine.sv =====
// Top level of the bit vector store engine: request sequencer, word store and word unit.
`default_nettype none

// The engine keeps a 1024-bit vector as 32 words of 32 bits in a small RAM, cleared at
// reset. Each request performs one operation chosen by func: set, clear or read one bit,
// clear everything, set an inclusive range, count the set bits, find the next set bit at
// or after an index, or write or read one whole word; every request yields exactly one
// response. The configuration register bits_in_use selects how many bits are live; it is
// rounded down to whole words and capped at 1024, and any index beyond that limit is
// answered with status 1 and changes nothing. Work is done one word per cycle: the
// sequencer streams word addresses into the RAM read port and the shared word unit
// masks, modifies, counts or searches each word as its read data returns, writing
// modified words back through the RAM write port. Set, clear, get and word read touch one
// word, a count walks every live word, set range walks the words of its range and find
// next walks from its start to the live limit, stopping at the first word with a hit.
// Clear all, word write and flagged requests skip the scan, since clear all just drops
// the per-word valid flags and a word write goes straight to the RAM. The engine holds
// req_stall high while it works on a request; a finished response sits in an output
// register, so a new request is taken while the previous response still waits for the
// consumer.

module bit_vector_store_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output      logic                        req_stall,
    input  wire bvse_pkg::req_t              req,
    output      logic                        rsp_valid,
    input  wire logic                        rsp_stall,
    output      bvse_pkg::rsp_t              rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bvse_pkg::CFG_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int WA = bvse_pkg::WORD_AW;
    localparam int BA = bvse_pkg::BIT_AW;
    localparam int NW = bvse_pkg::NWORDS_W;
    localparam logic [BA-1:0] BIT_MAX   = BA'(bvse_pkg::WORD_WIDTH - 1);
    localparam logic [NW-1:0] WORDS_CAP = NW'(bvse_pkg::STORE_WORDS);

    // Sequencer state.
    logic [1:0]                         state_reg,   state_next;
    logic [bvse_pkg::CFG_W-1:0]         biu_reg,     biu_next;
    logic [3:0]                         func_reg,    func_next;
    logic [BA-1:0]                      lo_bit_reg,  lo_bit_next;
    logic [BA-1:0]                      hi_bit_reg,  hi_bit_next;
    logic [WA-1:0]                      first_reg,   first_next;
    logic [WA-1:0]                      last_reg,    last_next;
    logic [WA-1:0]                      rd_ptr_reg,  rd_ptr_next;
    logic                               rd_done_reg, rd_done_next;
    logic                               pv_reg,      pv_next;
    logic [WA-1:0]                      paddr_reg,   paddr_next;
    logic                               pvld_reg,    pvld_next;
    logic [bvse_pkg::STORE_WORDS-1:0]   vbits_reg,   vbits_next;
    bvse_pkg::rsp_t                     res_reg,     res_next;
    bvse_pkg::rsp_t                     rsp_reg,     rsp_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    // Datapath signals.
    logic [NW-1:0]                      nwords;
    logic                               accept;
    logic                               ok_idx;
    logic                               ok_end;
    logic                               ok_word;
    logic                               rd_issue;
    logic                               proc;
    logic                               scan_end;
    logic [bvse_pkg::WORD_WIDTH-1:0]    ram_rdata;
    logic [bvse_pkg::WORD_WIDTH-1:0]    data_word;
    logic                               ram_we;
    logic [WA-1:0]                      ram_waddr;
    logic [bvse_pkg::WORD_WIDTH-1:0]    ram_wdata;
    logic                               wr_word_now;
    bvse_pkg::wu_ctl_t                  wu_ctl;
    bvse_pkg::wu_res_t                  wu_res;

    // Words in use: bits_in_use rounded down to whole words, capped at the store size.
    assign nwords = (biu_reg[bvse_pkg::CFG_W-1:BA] > WORDS_CAP) ? WORDS_CAP
                                                                : biu_reg[bvse_pkg::CFG_W-1:BA];

    // Comparing word numbers is enough, since the limit is a whole number of words.
    assign ok_idx  = {1'b0, req.bit_pos[bvse_pkg::INDEX_W-1:BA]} < nwords;
    assign ok_end  = {1'b0, req.end_index[bvse_pkg::INDEX_W-1:BA]} < nwords;
    assign ok_word = {1'b0, req.word_addr} < nwords;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);

    // A stored word that has not been written since the last clear reads as zero.
    assign data_word = pvld_reg ? ram_rdata : '0;

    assign proc     = pv_reg && (state_reg == ST_SCAN);
    assign scan_end = proc && ((paddr_reg == last_reg)
                               || ((func_reg == bvse_pkg::FN_FIND) && wu_res.hit));
    assign rd_issue = (state_reg == ST_SCAN) && !rd_done_reg && !scan_end;

    // Mask bounds for the word currently in the word unit. Ranges are only partial in their
    // first and last words, searches only in their first.
    always_comb
    begin
        wu_ctl.op = func_reg;
        wu_ctl.lo = '0;
        wu_ctl.hi = BIT_MAX;
        case (func_reg)
            bvse_pkg::FN_SET,
            bvse_pkg::FN_CLR,
            bvse_pkg::FN_GET:
            begin
                wu_ctl.lo = lo_bit_reg;
                wu_ctl.hi = lo_bit_reg;
            end
            bvse_pkg::FN_RANGE:
            begin
                wu_ctl.lo = (paddr_reg == first_reg) ? lo_bit_reg : '0;
                wu_ctl.hi = (paddr_reg == last_reg) ? hi_bit_reg : BIT_MAX;
            end
            bvse_pkg::FN_FIND:
            begin
                wu_ctl.lo = (paddr_reg == first_reg) ? lo_bit_reg : '0;
            end
            default:
            begin
                wu_ctl.lo = '0;
            end
        endcase
    end

    // A word write goes straight to the store in the cycle the request is accepted;
    // otherwise the write port carries words modified by the word unit.
    assign wr_word_now = accept && (req.func == bvse_pkg::FN_WR_WORD) && ok_word;
    assign ram_we      = wr_word_now || (proc && wu_res.wr_en);
    assign ram_waddr   = wr_word_now ? req.word_addr : paddr_reg;
    assign ram_wdata   = wr_word_now ? req.word_in : wu_res.wr_data;

    always_comb
    begin
        state_next     = state_reg;
        biu_next       = cfg_we ? cfg_data : biu_reg;
        func_next      = func_reg;
        lo_bit_next    = lo_bit_reg;
        hi_bit_next    = hi_bit_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_done_next   = rd_done_reg;
        pv_next        = rd_issue;
        paddr_next     = rd_ptr_reg;
        pvld_next      = vbits_reg[rd_ptr_reg];
        vbits_next     = vbits_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (ram_we)
        begin
            vbits_next[ram_waddr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next    = req.func;
                    lo_bit_next  = req.bit_pos[BA-1:0];
                    hi_bit_next  = req.end_index[BA-1:0];
                    first_next   = req.bit_pos[bvse_pkg::INDEX_W-1:BA];
                    last_next    = req.bit_pos[bvse_pkg::INDEX_W-1:BA];
                    rd_done_next = 1'b0;
                    res_next     = '0;
                    state_next   = ST_DONE;
                    case (req.func)
                        bvse_pkg::FN_SET,
                        bvse_pkg::FN_CLR,
                        bvse_pkg::FN_GET:
                        begin
                            if (ok_idx)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        bvse_pkg::FN_CLR_ALL:
                        begin
                            vbits_next = '0;
                        end
                        bvse_pkg::FN_RANGE:
                        begin
                            last_next = req.end_index[bvse_pkg::INDEX_W-1:BA];
                            if (!ok_idx || !ok_end)
                            begin
                                res_next.status = 1'b1;
                            end
                            else if (req.bit_pos <= req.end_index)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        bvse_pkg::FN_COUNT:
                        begin
                            first_next = '0;
                            last_next  = WA'(nwords - 1'b1);
                            if (nwords != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        bvse_pkg::FN_FIND:
                        begin
                            last_next = WA'(nwords - 1'b1);
                            if (ok_idx)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        bvse_pkg::FN_WR_WORD:
                        begin
                            res_next.status = !ok_word;
                        end
                        bvse_pkg::FN_RD_WORD:
                        begin
                            first_next = req.word_addr;
                            last_next  = req.word_addr;
                            if (ok_word)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.status = 1'b1;
                        end
                    endcase
                    rd_ptr_next = first_next;
                end
            end

            ST_SCAN:
            begin
                if (rd_issue)
                begin
                    if (rd_ptr_reg == last_reg)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end

                if (proc)
                begin
                    case (func_reg)
                        bvse_pkg::FN_GET:
                        begin
                            res_next.bit_value = wu_res.bit_val;
                        end
                        bvse_pkg::FN_COUNT:
                        begin
                            res_next.set_count = res_reg.set_count
                                               + bvse_pkg::COUNT_W'(wu_res.pop);
                        end
                        bvse_pkg::FN_FIND:
                        begin
                            if (wu_res.hit)
                            begin
                                res_next.found        = 1'b1;
                                res_next.active_index = {paddr_reg, wu_res.pos};
                            end
                        end
                        bvse_pkg::FN_RD_WORD:
                        begin
                            res_next.word_out = data_word;
                        end
                        default:
                        begin
                            res_next.status = res_reg.status;
                        end
                    endcase
                end

                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Load the output register once the previous response has been taken.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            biu_reg       <= bvse_pkg::BITS_IN_USE_RESET;
            rd_done_reg   <= 1'b0;
            pv_reg        <= 1'b0;
            vbits_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            biu_reg       <= biu_next;
            rd_done_reg   <= rd_done_next;
            pv_reg        <= pv_next;
            vbits_reg     <= vbits_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        lo_bit_reg <= lo_bit_next;
        hi_bit_reg <= hi_bit_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        rd_ptr_reg <= rd_ptr_next;
        paddr_reg  <= paddr_next;
        pvld_reg   <= pvld_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bvse_ram #(
        .WIDTH (bvse_pkg::WORD_WIDTH),
        .DEPTH (bvse_pkg::STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    bvse_word_unit u_word_unit (
        .ctl  (wu_ctl),
        .data (data_word),
        .res  (wu_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bvse_chk.sv =====
// Port-level checker for the bit vector store engine and its bind statement.
`default_nettype none

module bvse_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire bvse_pkg::rsp_t rsp
);

    // Every accepted request keeps the engine busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("engine took a request without going busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    // A flagged request reports nothing but its status.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (!rsp.bit_value && (rsp.set_count == '0)
            && !rsp.found && (rsp.active_index == '0) && (rsp.word_out == '0)))
        else $error("flagged response carries data");

    a_index_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.active_index == '0))
        else $error("index reported without a hit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.set_count <= bvse_pkg::COUNT_W'(bvse_pkg::STORE_WORDS
                                                           * bvse_pkg::WORD_WIDTH)))
        else $error("set count exceeds the vector size");

endmodule

bind bit_vector_store_engine bvse_chk u_bvse_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bit vector store engine: directed plan, then random phases.

// The testbench drives requests into the engine through the valid/stall handshake and
// keeps its own shadow copy of the bit vector and of the bits_in_use register. Every
// accepted request is applied to the shadow copy at the moment of acceptance, and the
// answer it yields is queued. Responses are compared field by field, in order, against
// that queue. A short directed plan covers the reset state, the edges of the vector, every
// operation and the flagged cases; a random part then runs through several register
// settings, from zero up to the largest value the register holds.
module tb_top;
    import bvse_pkg::*;

    // Operation codes beyond the defined set, which the engine must reject.
    localparam logic [3:0] FN_BAD_LO = 4'd9;
    localparam logic [3:0] FN_BAD_HI = 4'd15;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BOUNDS = 1'b1;

    localparam int VECTOR_BITS     = STORE_WORDS * WORD_WIDTH;
    localparam int RANDOM_REQUESTS = 1950;
    localparam int DRAIN_CYCLES    = 40;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CALM_PHASE      = 5;

    localparam rsp_t ANSWER_CLEAN   = '0;
    localparam rsp_t ANSWER_FLAGGED = '{status: STATUS_BOUNDS, default: '0};

    // One row of the directed plan: either a register write or a request, the latter
    // optionally with its answer typed in by hand.
    typedef struct {
        bit               cfg_write;
        logic [CFG_W-1:0] cfg_value;
        req_t             stim;
        bit               typed;
        rsp_t             want;
    } plan_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Shadow copy of the engine's storage and register.
    logic [WORD_WIDTH-1:0] shadow_words [STORE_WORDS] = '{default: '0};
    logic [CFG_W-1:0]      live_bits_cfg = BITS_IN_USE_RESET;

    rsp_t      answers_due [$];
    plan_row_t directed_plan [$];
    int        error_count = 0;
    bit        calm        = 1'b0;

    // Register settings of the random phases; a negative entry picks a random value.
    int phase_bits [14] = '{1024, 32, 0, 2047, 31, 1000, -1, 64, 33, 1023, 96, -1, 512,
                            1024};

    bit_vector_store_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run, several times the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // The live limit: the register rounded down to whole words, capped at the vector size.
    function automatic int live_limit();
        int lim;
        lim = (int'(live_bits_cfg) / WORD_WIDTH) * WORD_WIDTH;
        return (lim > VECTOR_BITS) ? VECTOR_BITS : lim;
    endfunction

    // Applies one request to the shadow vector and returns the answer the engine owes.
    function automatic rsp_t bitset_apply(input req_t r);
        rsp_t a;
        int   lim;
        int   nwords;
        int   idx;
        int   last;
        int   widx;
        int   total;
        a      = '0;
        lim    = live_limit();
        nwords = lim / WORD_WIDTH;
        idx    = int'(r.bit_pos);
        last   = int'(r.end_index);
        widx   = int'(r.word_addr);
        total  = 0;
        case (r.func)
            FN_SET, FN_CLR:
            begin
                if (idx >= lim)
                    a.status = STATUS_BOUNDS;
                else
                    shadow_words[idx / WORD_WIDTH][idx % WORD_WIDTH] = (r.func == FN_SET);
            end
            FN_GET:
            begin
                if (idx >= lim)
                    a.status = STATUS_BOUNDS;
                else
                    a.bit_value = shadow_words[idx / WORD_WIDTH][idx % WORD_WIDTH];
            end
            FN_CLR_ALL:
            begin
                // Words beyond the live limit are cleared as well.
                foreach (shadow_words[w])
                    shadow_words[w] = '0;
            end
            FN_RANGE:
            begin
                // A range with its start past its end is legal and sets nothing.
                if (idx >= lim || last >= lim)
                    a.status = STATUS_BOUNDS;
                else
                    for (int i = idx; i <= last; i++)
                        shadow_words[i / WORD_WIDTH][i % WORD_WIDTH] = 1'b1;
            end
            FN_COUNT:
            begin
                for (int i = 0; i < nwords; i++)
                    total += $countones(shadow_words[i]);
                a.set_count = COUNT_W'(total);
            end
            FN_FIND:
            begin
                if (idx >= lim)
                    a.status = STATUS_BOUNDS;
                else
                    for (int i = idx; i < lim; i++)
                    begin
                        if (shadow_words[i / WORD_WIDTH][i % WORD_WIDTH])
                        begin
                            a.found        = 1'b1;
                            a.active_index = INDEX_W'(i);
                            break;
                        end
                    end
            end
            FN_WR_WORD:
            begin
                if (widx >= nwords)
                    a.status = STATUS_BOUNDS;
                else
                    shadow_words[widx] = r.word_in;
            end
            FN_RD_WORD:
            begin
                if (widx >= nwords)
                    a.status = STATUS_BOUNDS;
                else
                    a.word_out = shadow_words[widx];
            end
            default:
                a.status = STATUS_BOUNDS;
        endcase
        return a;
    endfunction

    function automatic plan_row_t op_row(input logic [3:0] f, input int bi, input int ei,
                                         input int wi, input logic [WORD_WIDTH-1:0] wv);
        plan_row_t row;
        row.cfg_write        = 1'b0;
        row.cfg_value        = '0;
        row.stim.func        = f;
        row.stim.bit_pos     = INDEX_W'(bi);
        row.stim.end_index   = INDEX_W'(ei);
        row.stim.word_addr   = WORD_AW'(wi);
        row.stim.word_in     = wv;
        row.typed            = 1'b0;
        row.want             = '0;
        return row;
    endfunction

    function automatic plan_row_t checked_row(input plan_row_t row, input rsp_t want);
        plan_row_t r;
        r       = row;
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input int v);
        plan_row_t row;
        row           = op_row(FN_SET, 0, 0, 0, '0);
        row.cfg_write = 1'b1;
        row.cfg_value = CFG_W'(v);
        return row;
    endfunction

    // Random indexes mostly fall inside the live limit, with the rest anywhere in the field.
    function automatic int near_index(input int lim);
        if (lim > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, lim - 1);
        return $urandom_range(0, VECTOR_BITS - 1);
    endfunction

    function automatic req_t random_request(input int lim);
        req_t r;
        int   pick;
        int   nwords;
        int   last;
        nwords = lim / WORD_WIDTH;
        pick   = $urandom_range(0, 99);
        if (pick < 18)
            r.func = FN_SET;
        else if (pick < 28)
            r.func = FN_CLR;
        else if (pick < 40)
            r.func = FN_GET;
        else if (pick < 43)
            r.func = FN_CLR_ALL;
        else if (pick < 53)
            r.func = FN_RANGE;
        else if (pick < 61)
            r.func = FN_COUNT;
        else if (pick < 75)
            r.func = FN_FIND;
        else if (pick < 84)
            r.func = FN_WR_WORD;
        else if (pick < 95)
            r.func = FN_RD_WORD;
        else
            r.func = 4'($urandom_range(FN_BAD_LO, FN_BAD_HI));
        r.bit_pos = INDEX_W'(near_index(lim));
        last      = near_index(lim);
        // Most set-range requests are short runs; a few have their end before their start.
        if (r.func == FN_RANGE && $urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 7) == 0)
                last = int'(r.bit_pos) - 1;
            else
                last = int'(r.bit_pos) + int'($urandom_range(0, 40));
            if (last < 0)
                last = 0;
            if (last > VECTOR_BITS - 1)
                last = VECTOR_BITS - 1;
        end
        r.end_index = INDEX_W'(last);
        if (nwords > 0 && $urandom_range(0, 4) != 0)
            r.word_addr = WORD_AW'($urandom_range(0, nwords - 1));
        else
            r.word_addr = WORD_AW'($urandom_range(0, STORE_WORDS - 1));
        case ($urandom_range(0, 3))
            0:       r.word_in = '0;
            1:       r.word_in = '1;
            2:       r.word_in = WORD_WIDTH'(1) << $urandom_range(0, WORD_WIDTH - 1);
            default: r.word_in = $urandom;
        endcase
        return r;
    endfunction

    // The sender drops valid now and then, unless the phase is calm.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Presents one request, holds it until the engine takes it, and queues its answer.
    // Called at a falling edge and returns at a falling edge.
    task automatic push_req(input req_t r, input bit typed, input rsp_t want,
                            output rsp_t predicted);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = bitset_apply(r);
        answers_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Stops sending and waits until every queued answer has come back.
    task automatic settle_engine();
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes bits_in_use once the engine has gone idle.
    task automatic program_bits(input logic [CFG_W-1:0] v);
        settle_engine();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we        <= 1'b0;
        live_bits_cfg  = v;
    endtask

    task automatic compare_field(input string name, input logic [WORD_WIDTH-1:0] want,
                                 input logic [WORD_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // The consumer stalls on about fifteen percent of cycles, except in the calm phase.
    always @(negedge clk)
    begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    // Every accepted response is matched against the oldest queued answer.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t ns: unexpected response, expected none, got 0x%0h", $time, rsp);
                error_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                compare_field("bit_value", want.bit_value, rsp.bit_value);
                compare_field("set_count", want.set_count, rsp.set_count);
                compare_field("active_index", want.active_index, rsp.active_index);
                compare_field("found", want.found, rsp.found);
                compare_field("word_out", want.word_out, rsp.word_out);
                compare_field("status", want.status, rsp.status);
            end
        end
    end

    initial
    begin
        rsp_t             predicted;
        rsp_t             full_count;
        req_t             probe_req;
        int               per_phase;
        int               sent;
        int               probe;
        int               hops;
        int               lim;
        logic [CFG_W-1:0] setting;

        full_count           = '0;
        full_count.set_count = COUNT_W'(VECTOR_BITS);

        // Directed plan. The first rows see the vector as reset left it; then both ends of
        // the vector, whole words, ranges (an empty one and the full vector), clear all and
        // undefined operation codes. The last rows shrink the live limit to one word and
        // then to nothing, so that indexed requests beyond it are flagged.
        directed_plan.push_back(checked_row(op_row(FN_GET, 0, 0, 0, '0), ANSWER_CLEAN));
        directed_plan.push_back(checked_row(op_row(FN_COUNT, 0, 0, 0, '0), ANSWER_CLEAN));
        directed_plan.push_back(checked_row(op_row(FN_FIND, 0, 0, 0, '0), ANSWER_CLEAN));
        directed_plan.push_back(checked_row(op_row(FN_RD_WORD, 0, 0, 31, '0), ANSWER_CLEAN));
        directed_plan.push_back(op_row(FN_SET, 0, 0, 0, '0));
        directed_plan.push_back(op_row(FN_SET, 1023, 0, 0, '0));
        directed_plan.push_back(op_row(FN_WR_WORD, 0, 0, 5, 32'hFFFF_FFFF));
        directed_plan.push_back(op_row(FN_WR_WORD, 0, 0, 30, 32'h8000_0001));
        directed_plan.push_back(op_row(FN_GET, 1023, 0, 0, '0));
        directed_plan.push_back(op_row(FN_CLR, 1023, 0, 0, '0));
        directed_plan.push_back(op_row(FN_RANGE, 100, 300, 0, '0));
        directed_plan.push_back(op_row(FN_RANGE, 500, 499, 0, '0));
        directed_plan.push_back(op_row(FN_FIND, 301, 0, 0, '0));
        directed_plan.push_back(op_row(FN_COUNT, 0, 0, 0, '0));
        directed_plan.push_back(op_row(FN_RANGE, 0, 1023, 0, '0));
        directed_plan.push_back(checked_row(op_row(FN_COUNT, 0, 0, 0, '0), full_count));
        directed_plan.push_back(op_row(FN_CLR_ALL, 0, 0, 0, '0));
        directed_plan.push_back(checked_row(op_row(FN_FIND, 0, 0, 0, '0), ANSWER_CLEAN));
        directed_plan.push_back(checked_row(op_row(FN_BAD_LO, 0, 0, 0, '0), ANSWER_FLAGGED));
        directed_plan.push_back(checked_row(op_row(FN_BAD_HI, 1023, 1023, 31, '1),
                                            ANSWER_FLAGGED));
        directed_plan.push_back(cfg_row(32));
        directed_plan.push_back(checked_row(op_row(FN_SET, 32, 0, 0, '0), ANSWER_FLAGGED));
        directed_plan.push_back(checked_row(op_row(FN_RANGE, 0, 32, 0, '0), ANSWER_FLAGGED));
        directed_plan.push_back(checked_row(op_row(FN_WR_WORD, 0, 0, 1, '1), ANSWER_FLAGGED));
        directed_plan.push_back(op_row(FN_FIND, 31, 0, 0, '0));
        directed_plan.push_back(op_row(FN_RD_WORD, 0, 0, 0, '0));
        directed_plan.push_back(cfg_row(0));
        directed_plan.push_back(checked_row(op_row(FN_COUNT, 0, 0, 0, '0), ANSWER_CLEAN));
        directed_plan.push_back(checked_row(op_row(FN_GET, 0, 0, 0, '0), ANSWER_FLAGGED));

        // Reset is held low at first and released away from the rising edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[n])
        begin
            if (directed_plan[n].cfg_write)
                program_bits(directed_plan[n].cfg_value);
            else
                push_req(directed_plan[n].stim, directed_plan[n].typed, directed_plan[n].want,
                         predicted);
        end

        // Random phases, each under its own register setting. Writing the register first
        // drains the engine, so the sender pauses for every answer at least once per phase.
        per_phase = RANDOM_REQUESTS / $size(phase_bits);
        for (int phase = 0; phase < $size(phase_bits); phase++)
        begin
            if (phase_bits[phase] < 0)
                setting = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            else
                setting = CFG_W'(phase_bits[phase]);
            program_bits(setting);
            calm = (phase == CALM_PHASE);
            lim  = live_limit();
            sent = 0;
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 99) == 0)
                    settle_engine();
                sender_gap();
                if (lim > 0 && $urandom_range(0, 99) < 4)
                begin
                    // List the set bits from a random start the way software does it: each
                    // find-next request starts one past the bit the previous one found.
                    probe = $urandom_range(0, lim - 1);
                    hops  = 0;
                    while (hops < 10 && probe < lim)
                    begin
                        probe_req         = random_request(lim);
                        probe_req.func    = FN_FIND;
                        probe_req.bit_pos = INDEX_W'(probe);
                        push_req(probe_req, 1'b0, '0, predicted);
                        hops++;
                        probe = predicted.found ? int'(predicted.active_index) + 1 : lim;
                    end
                    sent += hops;
                end
                else
                begin
                    push_req(random_request(lim), 1'b0, '0, predicted);
                    sent++;
                end
            end
        end

        calm = 1'b0;
        settle_engine();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
